>>> rtl/core/sobel_pkg.sv
// Package with the shared constants and types of the Sobel edge threshold unit.
`default_nettype none

package sobel_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int IDX_W   = 2;
	localparam int SUM_W   = 10;

	localparam logic [PIX_W-1:0] MAG_LIMIT = 8'd255;

	localparam logic [DIM_W-1:0] WIDTH_RST     = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd480;
	localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd180;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	typedef struct packed {
		logic                 win_ok;
		logic [COORD_W-1:0]   center_row;
		logic [COORD_W-1:0]   center_col;
		logic                 frame_end;
	} item_tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] lower;
	} line_pair_t;

endpackage

`default_nettype wire

>>> rtl/core/sobel_edge_threshold_unit.sv
// An accepted pixel is registered in stage 1, then stage 2, then the output register.
// Throughput: one pixel per cycle while not stalled, set by the simple dual-port line memory
// (one read and one write of the same row pair per pixel, at different columns in any one cycle).
// Reset: asynchronous; clears counters, window, valids and loads the register defaults.
// The line memory is not cleared; its entries are written during the first two rows.
`default_nettype none

module sobel_edge_threshold_unit #(
	parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire  [sobel_pkg::IDX_W-1:0]      cfg_index,
	input  wire  [sobel_pkg::DIM_W-1:0]      cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [sobel_pkg::PIX_W-1:0]      gray_pixel,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [sobel_pkg::PIX_W-1:0]      vert_gradient,
	output logic [sobel_pkg::PIX_W-1:0]      horz_gradient,
	output logic                             window_valid,
	output logic [sobel_pkg::COORD_W-1:0]    center_row,
	output logic [sobel_pkg::COORD_W-1:0]    center_col,
	output logic                             frame_end
);
	import sobel_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int XW = (CW > COORD_W) ? CW : COORD_W;

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [PIX_W-1:0] edge_threshold_q;

	logic [CW-1:0]      col_q;
	logic [COORD_W-1:0] row_q;

	line_pair_t line_mem [MAX_WIDTH];
	line_pair_t mem_rd_q;

	logic [PIX_W-1:0] win_mid_q   [3];
	logic [PIX_W-1:0] win_right_q [3];

	logic             valid_s1, valid_s2, out_valid_q;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] pix_s1;
	item_tag_t        tag_s1, tag_s2;
	logic [SUM_W-1:0] top_s2, bot_s2, left_s2, right_s2;

	logic [PIX_W-1:0]   vert_q, horz_q;
	item_tag_t          tag_q;

	logic en_out, en_s2, accept, advance_s1;

	logic [DW-1:0]    fw_x, eff_w;
	logic [DIM_W-1:0] eff_h;
	logic             row_end, last_row, win_ok;
	logic [XW-1:0]    col_x;
	item_tag_t        tag_new;

	logic [SUM_W-1:0] top_sum, bot_sum, left_sum, right_sum;
	logic [SUM_W-1:0] vert_mag, horz_mag;
	logic [PIX_W-1:0] vert_fin, horz_fin;

	function automatic logic [PIX_W-1:0] finish_mag(
		input logic [SUM_W-1:0] mag,
		input logic [PIX_W-1:0] thr
	);
		logic [PIX_W-1:0] clamped;
		begin
			clamped = (mag > SUM_W'(MAG_LIMIT)) ? MAG_LIMIT : mag[PIX_W-1:0];
			finish_mag = (clamped < thr) ? '0 : clamped;
		end
	endfunction

	assign en_out     = !out_valid_q || out_ready;
	assign en_s2      = !valid_s2 || en_out;
	assign in_ready   = !valid_s1 || en_s2;
	assign accept     = in_valid && in_ready;
	assign advance_s1 = valid_s1 && en_s2;

	always_comb begin
		fw_x = DW'(frame_width_q);
		if (fw_x < DW'(3)) begin
			eff_w = DW'(3);
		end else if (fw_x > DW'(MAX_WIDTH)) begin
			eff_w = DW'(MAX_WIDTH);
		end else begin
			eff_w = fw_x;
		end
		if (frame_height_q < 13'd3) begin
			eff_h = 13'd3;
		end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = frame_height_q;
		end
		row_end  = (DW'(col_q) + DW'(1)) >= eff_w;
		last_row = (DIM_W'(row_q) + 13'd1) >= eff_h;
		win_ok   = (row_q >= 12'd2) && (DW'(col_q) >= DW'(2));
		col_x    = XW'(col_q);
		tag_new.win_ok     = win_ok;
		tag_new.center_row = win_ok ? (row_q - 12'd1) : '0;
		tag_new.center_col = win_ok ? (col_x[COORD_W-1:0] - 12'd1) : '0;
		tag_new.frame_end  = row_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= WIDTH_RST;
			frame_height_q   <= HEIGHT_RST;
			edge_threshold_q <= THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data;
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data;
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_q + 12'd1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_rd_q <= line_mem[col_q];
		end
		if (advance_s1) begin
			line_mem[col_s1] <= '{upper: mem_rd_q.lower, lower: pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			pix_s1 <= gray_pixel;
			tag_s1 <= tag_new;
		end
	end

	always_comb begin
		top_sum   = SUM_W'(win_mid_q[0]) + {1'b0, win_right_q[0], 1'b0}
		          + SUM_W'(mem_rd_q.upper);
		bot_sum   = SUM_W'(win_mid_q[2]) + {1'b0, win_right_q[2], 1'b0} + SUM_W'(pix_s1);
		left_sum  = SUM_W'(win_mid_q[0]) + {1'b0, win_mid_q[1], 1'b0} + SUM_W'(win_mid_q[2]);
		right_sum = SUM_W'(mem_rd_q.upper) + {1'b0, mem_rd_q.lower, 1'b0} + SUM_W'(pix_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_mid_q[r]   <= '0;
				win_right_q[r] <= '0;
			end
		end else if (advance_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_mid_q[r] <= win_right_q[r];
			end
			win_right_q[0] <= mem_rd_q.upper;
			win_right_q[1] <= mem_rd_q.lower;
			win_right_q[2] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			top_s2   <= top_sum;
			bot_s2   <= bot_sum;
			left_s2  <= left_sum;
			right_s2 <= right_sum;
			tag_s2   <= tag_s1;
		end
	end

	always_comb begin
		vert_mag = (top_s2 >= bot_s2) ? (top_s2 - bot_s2) : (bot_s2 - top_s2);
		horz_mag = (left_s2 >= right_s2) ? (left_s2 - right_s2) : (right_s2 - left_s2);
		vert_fin = tag_s2.win_ok ? finish_mag(vert_mag, edge_threshold_q) : '0;
		horz_fin = tag_s2.win_ok ? finish_mag(horz_mag, edge_threshold_q) : '0;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			vert_q <= vert_fin;
			horz_q <= horz_fin;
			tag_q  <= tag_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign vert_gradient = vert_q;
	assign horz_gradient = horz_q;
	assign window_valid  = tag_q.win_ok;
	assign center_row    = tag_q.center_row;
	assign center_col    = tag_q.center_col;
	assign frame_end     = tag_q.frame_end;

endmodule

`default_nettype wire
